[hw/rtl/zbuffer_depth_test_core_macros.svh]
// Assertion helpers for the depth test core.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef ZBUFFER_DEPTH_TEST_CORE_MACROS_SVH
`define ZBUFFER_DEPTH_TEST_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define ZDT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define ZDT_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ZDT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ZDT_ASSERT_ALWAYS(lbl, prop, msg)
`define ZDT_ASSERT_IMPLY(lbl, ante, cons, msg)
`define ZDT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/zdt_pkg.sv]
`timescale 1ns / 1ps
package zdt_pkg;

    localparam int unsigned DEPTH_WORDS_DEF = 65536;

    localparam int DATA_W     = 32;
    localparam int BASE_W     = 16;
    localparam int PIX_W      = 10;
    localparam int STRIDE_W   = 16;
    localparam int ROW_OFF_W  = PIX_W + STRIDE_W;
    // base + y * stride + x never exceeds this width
    localparam int SUM_W      = ROW_OFF_W + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_STRIDE = 2'd2;

    localparam logic OP_TEST = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd256;

    // result queue depth, power of two
    localparam int RES_FIFO_DEPTH = 8;

    typedef enum logic [1:0] {
        MODE_NEVER   = 2'd0,
        MODE_LESS    = 2'd1,
        MODE_GREATER = 2'd2,
        MODE_ALWAYS  = 2'd3
    } t_depth_mode;

    typedef struct packed {
        logic signed [DATA_W-1:0] mask_value;
        logic                     last_out;
    } t_result;

endpackage

[hw/rtl/zdt_if.sv]
`timescale 1ns / 1ps
interface zdt_pix_if;
    logic                               valid;
    logic                               ready;
    logic                               operation;
    logic [zdt_pkg::BASE_W-1:0]         window_base;
    logic [zdt_pkg::PIX_W-1:0]          pixel_x;
    logic [zdt_pkg::PIX_W-1:0]          pixel_y;
    logic signed [zdt_pkg::DATA_W-1:0]  src_depth;
    logic                               is_last;

    modport source (output valid, operation, window_base, pixel_x, pixel_y, src_depth,
                    is_last, input ready);
    modport sink (input valid, operation, window_base, pixel_x, pixel_y, src_depth,
                  is_last, output ready);
endinterface

interface zdt_res_if;
    logic                               valid;
    logic                               ready;
    logic signed [zdt_pkg::DATA_W-1:0]  mask_value;
    logic                               last_out;

    modport source (output valid, mask_value, last_out, input ready);
    modport sink (input valid, mask_value, last_out, output ready);
endinterface

interface zdt_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [zdt_pkg::CFG_IDX_W-1:0]      index;
    logic [zdt_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/zbuffer_depth_test_core.sv]
`timescale 1ns / 1ps
`include "zbuffer_depth_test_core_macros.svh"
// Depth test against an on-chip depth buffer of DEPTH_WORDS 32-bit words.
// i_pix: one transaction per fragment. operation test reads the word at
//   (window_base + pixel_y * image_stride + pixel_x) mod DEPTH_WORDS, forms the
//   mask and may write src_depth back; operation load writes src_depth at
//   window_base mod DEPTH_WORDS and gives no result.
// o_res: one transaction per test fragment, in input order (mask_value, last_out).
// i_cfg: register writes (0 depth_mode, 1 write_enable, 2 image_stride), always
//   ready; write only while no fragment is in flight.
// Throughput: one fragment per cycle while i_pix.ready is high. A fragment passes
//   through the address add, the modulo reduction multiply, the memory read, then
//   compare and write back into the result queue. Back-to-back hits on the same
//   word are forwarded from the write port into the next compare.
// The buffer holds whatever it held before reset; words must be loaded or
//   written before they are tested.
// Stall: a result queue of 8 entries absorbs results; i_pix.ready drops once 8
//   fragments are pending between input and output, so nothing is lost.
// Reset: synchronous, active low; registers return to less / write on / 256.
module zbuffer_depth_test_core #(
    parameter int unsigned DEPTH_WORDS = zdt_pkg::DEPTH_WORDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    zdt_pix_if.sink    i_pix,
    zdt_res_if.source  o_res,
    zdt_cfg_if.sink    i_cfg
);
    localparam int AW     = (DEPTH_WORDS > 1) ? $clog2(DEPTH_WORDS) : 1;
    localparam int SW     = zdt_pkg::SUM_W;
    localparam int DW     = zdt_pkg::DATA_W;
    localparam int K      = SW + AW;
    localparam int RW     = SW + 1;
    localparam int PW     = SW + RW;
    localparam int PEND_W = $clog2(zdt_pkg::RES_FIFO_DEPTH + 1);
    // floor(2^K / D): quotient estimate is exact or one low
    localparam logic [63:0]   RECIP_FULL = (64'd1 << K) / 64'(DEPTH_WORDS);
    localparam logic [RW-1:0] RECIP      = RECIP_FULL[RW-1:0];
    localparam logic [SW-1:0] DEPTH_C    = SW'(DEPTH_WORDS);

    // configuration
    zdt_pkg::t_depth_mode              r_depth_mode;
    logic                              r_write_en;
    logic [zdt_pkg::STRIDE_W-1:0]      r_stride;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_mode <= zdt_pkg::MODE_LESS;
            r_write_en   <= 1'b1;
            r_stride     <= zdt_pkg::STRIDE_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                zdt_pkg::CFG_DEPTH_MODE:   r_depth_mode <= zdt_pkg::t_depth_mode'(i_cfg.data[1:0]);
                zdt_pkg::CFG_WRITE_ENABLE: r_write_en   <= i_cfg.data[0];
                zdt_pkg::CFG_IMAGE_STRIDE: r_stride     <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // stage A: address sum
    logic                         accept;
    logic [zdt_pkg::ROW_OFF_W-1:0] a_row_off;
    logic [SW-1:0]                a_sum;

    assign accept    = i_pix.valid && i_pix.ready;
    assign a_row_off = zdt_pkg::ROW_OFF_W'(i_pix.pixel_y) * zdt_pkg::ROW_OFF_W'(r_stride);
    assign a_sum     = (i_pix.operation == zdt_pkg::OP_LOAD) ? SW'(i_pix.window_base)
                     : SW'(i_pix.window_base) + SW'(a_row_off) + SW'(i_pix.pixel_x);

    logic          r_a_valid, r_a_op, r_a_last;
    logic [SW-1:0] r_a_sum;
    logic [DW-1:0] r_a_src;

    // stage B: quotient estimate
    logic [PW-1:0] b_prod;
    logic [SW-1:0] b_q;

    assign b_prod = PW'(r_a_sum) * PW'(RECIP);
    assign b_q    = SW'(b_prod >> K);

    logic          r_b_valid, r_b_op, r_b_last;
    logic [SW-1:0] r_b_sum;
    logic [SW-1:0] r_b_q;
    logic [DW-1:0] r_b_src;

    // remainder and memory read address
    logic [SW-1:0] b_rem_raw;
    logic [SW-1:0] b_rem;
    logic [AW-1:0] b_addr;

    assign b_rem_raw = r_b_sum - SW'(r_b_q * DEPTH_C);
    assign b_rem     = (b_rem_raw >= DEPTH_C) ? b_rem_raw - DEPTH_C : b_rem_raw;
    assign b_addr    = b_rem[AW-1:0];

    // stage C: read-modify-write
    logic          r_c_valid, r_c_op, r_c_last;
    logic [AW-1:0] r_c_addr;
    logic [DW-1:0] r_c_src;

    logic [DW-1:0] r_mem [DEPTH_WORDS];
    logic [DW-1:0] r_rdata;
    logic          r_fwd_hit;
    logic [DW-1:0] r_fwd_data;

    logic [DW-1:0] c_buf;
    logic [DW-1:0] c_mask;
    logic          c_store;
    logic          c_wr_en;
    logic          c_push;

    assign c_buf = r_fwd_hit ? r_fwd_data : r_rdata;

    always_comb begin
        case (r_depth_mode)
            zdt_pkg::MODE_LESS: begin
                c_mask  = r_c_src - c_buf;
                c_store = c_mask[DW-1];
            end
            zdt_pkg::MODE_GREATER: begin
                c_mask  = c_buf - r_c_src;
                c_store = c_mask[DW-1];
            end
            zdt_pkg::MODE_ALWAYS: begin
                c_mask  = '1;
                c_store = 1'b1;
            end
            default: begin
                c_mask  = '0;
                c_store = 1'b0;
            end
        endcase
    end

    assign c_wr_en = r_c_valid && ((r_c_op == zdt_pkg::OP_LOAD) || (c_store && r_write_en));
    assign c_push  = r_c_valid && (r_c_op == zdt_pkg::OP_TEST);

    always_ff @(posedge i_clk) begin
        if (c_wr_en) begin
            r_mem[r_c_addr] <= r_c_src;
        end
        r_rdata <= r_mem[b_addr];
    end

    // the word written this cycle is not yet visible to the read issued alongside
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= c_wr_en && r_b_valid && (r_c_addr == b_addr);
        end
        r_fwd_data <= r_c_src;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
        r_a_op   <= i_pix.operation;
        r_a_sum  <= a_sum;
        r_a_src  <= i_pix.src_depth;
        r_a_last <= i_pix.is_last;
        r_b_op   <= r_a_op;
        r_b_sum  <= r_a_sum;
        r_b_q    <= b_q;
        r_b_src  <= r_a_src;
        r_b_last <= r_a_last;
        r_c_op   <= r_b_op;
        r_c_addr <= b_addr;
        r_c_src  <= r_b_src;
        r_c_last <= r_b_last;
    end

    // result queue
    zdt_pkg::t_result c_result;
    zdt_pkg::t_result q_head;
    logic             q_valid;
    logic             pop;

    assign c_result.mask_value = c_mask;
    assign c_result.last_out   = r_c_last;
    assign pop                 = o_res.valid && o_res.ready;

    zdt_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (c_push),
        .i_data  (c_result),
        .i_pop   (o_res.ready),
        .o_valid (q_valid),
        .o_data  (q_head)
    );

    assign o_res.valid      = q_valid;
    assign o_res.mask_value = q_head.mask_value;
    assign o_res.last_out   = q_head.last_out;

    // fragments accepted and not yet delivered or retired as loads
    logic [PEND_W-1:0] r_pending;
    logic [PEND_W-1:0] n_pending;
    logic              load_retire;

    assign load_retire = r_c_valid && (r_c_op == zdt_pkg::OP_LOAD);
    assign n_pending   = r_pending + PEND_W'(accept) - PEND_W'(pop) - PEND_W'(load_retire);
    assign i_pix.ready = (r_pending < PEND_W'(zdt_pkg::RES_FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    `ZDT_ASSERT_ALWAYS(a_pending_bound, r_pending <= PEND_W'(zdt_pkg::RES_FIFO_DEPTH), "pending count out of range")
    `ZDT_ASSERT_IMPLY(a_out_has_pending, o_res.valid, r_pending != '0, "result without pending fragment")
    `ZDT_ASSERT_NEXT(a_fwd_taken, c_wr_en && r_b_valid && (r_c_addr == b_addr), r_fwd_hit && r_c_valid, "write not forwarded")
    `ZDT_ASSERT_IMPLY(a_fwd_valid, r_fwd_hit, r_c_valid, "forward without item")

endmodule

[hw/rtl/zdt_res_fifo.sv]
`timescale 1ns / 1ps
`include "zbuffer_depth_test_core_macros.svh"
module zdt_res_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  zdt_pkg::t_result i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output zdt_pkg::t_result o_data
);
    localparam int DEPTH = zdt_pkg::RES_FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    zdt_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             full;
    logic             pop_ok;

    assign full    = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, pop_ok})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `ZDT_ASSERT_IMPLY(a_no_overflow, i_push, !full || pop_ok, "result queue overflow")
    `ZDT_ASSERT_NEXT(a_pop_moves, pop_ok && !i_push, r_count == $past(r_count) - CNT_W'(1), "pop lost")

endmodule

[test/zdt_depth_compare.sv]
`timescale 1ns / 1ps
module zdt_depth_compare #(
    parameter int unsigned DEPTH_WORDS = zdt_pkg::DEPTH_WORDS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    zdt_pix_if   pix,
    zdt_res_if   res,
    zdt_cfg_if   cfg,
    output int   o_errors,
    output int   o_pending
);
    import zdt_pkg::*;

    t_depth_mode           mode_r;
    logic                  wr_en_r;
    logic [STRIDE_W-1:0]   stride_r;
    logic [DATA_W-1:0]     depth_mem [DEPTH_WORDS];
    t_result               mask_q [$];

    function automatic int unsigned pixel_addr(logic [BASE_W-1:0] base,
                                               logic [PIX_W-1:0] x,
                                               logic [PIX_W-1:0] y);
        longint unsigned sum;
        sum = longint'(base) + longint'(y) * longint'(stride_r) + longint'(x);
        return int'(sum % DEPTH_WORDS);
    endfunction

    // o_errors and o_pending are two-state and start at zero
    always @(posedge i_clk) begin : watch
        t_result           want;
        int unsigned       addr;
        logic [DATA_W-1:0] src;
        logic [DATA_W-1:0] stored;
        logic [DATA_W-1:0] mask;
        logic              pass;
        if (!i_rst_n) begin
            mode_r   = MODE_LESS;
            wr_en_r  = 1'b1;
            stride_r = STRIDE_RESET;
            mask_q.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_DEPTH_MODE:   mode_r = t_depth_mode'(cfg.data[1:0]);
                    CFG_WRITE_ENABLE: wr_en_r = cfg.data[0];
                    CFG_IMAGE_STRIDE: stride_r = cfg.data[STRIDE_W-1:0];
                    default: ;
                endcase
            end

            if (res.valid && res.ready) begin
                if (mask_q.size() == 0) begin
                    $display("%0t: unexpected result mask_value %0d last_out %0b",
                             $time, res.mask_value, res.last_out);
                    o_errors++;
                end else begin
                    want = mask_q.pop_front();
                    if (res.mask_value !== want.mask_value) begin
                        $display("%0t: mask_value expected %0d (%h) got %0d (%h)", $time,
                                 want.mask_value, want.mask_value,
                                 res.mask_value, res.mask_value);
                        o_errors++;
                    end
                    if (res.last_out !== want.last_out) begin
                        $display("%0t: last_out expected %0b got %0b", $time,
                                 want.last_out, res.last_out);
                        o_errors++;
                    end
                end
            end

            if (pix.valid && pix.ready) begin
                src = pix.src_depth;
                if (pix.operation == OP_LOAD) begin
                    depth_mem[pix.window_base % DEPTH_WORDS] = src;
                end else begin
                    addr   = pixel_addr(pix.window_base, pix.pixel_x, pix.pixel_y);
                    stored = depth_mem[addr];
                    case (mode_r)
                        MODE_LESS: begin
                            mask = src - stored;
                            pass = mask[DATA_W-1];
                        end
                        MODE_GREATER: begin
                            mask = stored - src;
                            pass = mask[DATA_W-1];
                        end
                        MODE_ALWAYS: begin
                            mask = '1;
                            pass = 1'b1;
                        end
                        default: begin
                            // never: no pass, no store
                            mask = '0;
                            pass = 1'b0;
                        end
                    endcase
                    if (pass && wr_en_r)
                        depth_mem[addr] = src;
                    want.mask_value = mask;
                    want.last_out   = pix.is_last;
                    mask_q.push_back(want);
                end
            end
        end
        o_pending = mask_q.size();
    end

endmodule

[test/tb_zbuffer_depth_test_core.sv]
`timescale 1ns / 1ps
module tb_zbuffer_depth_test_core;
    import zdt_pkg::*;

    localparam int unsigned N_WORDS      = DEPTH_WORDS_DEF;
    localparam int          RAND_ITEMS   = 1750;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 1000000;
    // index past the register list, must be a no-op
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic clk;
    logic rst_n;

    zdt_pix_if pix ();
    zdt_res_if res ();
    zdt_cfg_if cfg ();

    int errors;
    int pending;
    int n_items;
    bit calm;

    logic [STRIDE_W-1:0] stride_now;
    int unsigned         loaded_q [$];
    bit                  loaded_map [N_WORDS];
    int unsigned         last_target;

    zbuffer_depth_test_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    zdt_depth_compare #(.DEPTH_WORDS(N_WORDS)) u_depth_compare (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .pix       (pix),
        .res       (res),
        .cfg       (cfg),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] pick_depth();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 32'($urandom_range(0, 127)) - 32'd64;
        else if (r < 80)
            return $urandom;
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_coord();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        return PIX_W'($urandom_range(0, 1023));
    endfunction

    // result side back-pressure
    initial begin : res_stall
        int stall;
        res.ready = 1'b1;
        forever begin
            repeat ($urandom_range(1, 24)) @(negedge clk);
            stall = idle_len();
            if (stall > 0) begin
                res.ready = 1'b0;
                repeat (stall) @(negedge clk);
                res.ready = 1'b1;
            end
        end
    end

    // entered and left at a falling edge
    task automatic push_frag(logic op, logic [BASE_W-1:0] base, logic [PIX_W-1:0] x,
                             logic [PIX_W-1:0] y, logic [DATA_W-1:0] src, logic last);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            pix.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix.valid       = 1'b1;
        pix.operation   = op;
        pix.window_base = base;
        pix.pixel_x     = x;
        pix.pixel_y     = y;
        pix.src_depth   = src;
        pix.is_last     = last;
        @(posedge clk);
        while (!pix.ready) @(posedge clk);
        @(negedge clk);
        n_items++;
    endtask

    task automatic load_word(int unsigned addr, logic [DATA_W-1:0] src);
        push_frag(OP_LOAD, BASE_W'(addr), PIX_W'($urandom), PIX_W'($urandom), src,
                  1'($urandom));
        if (!loaded_map[addr]) begin
            loaded_map[addr] = 1'b1;
            loaded_q.push_back(addr);
        end
    endtask

    // picks the window base so that the pixel lands on a loaded word
    task automatic test_at(int unsigned target, logic [PIX_W-1:0] x, logic [PIX_W-1:0] y,
                           logic [DATA_W-1:0] src, logic last);
        int unsigned base;
        base = target - y * stride_now - x;
        push_frag(OP_TEST, BASE_W'(base), x, y, src, last);
        last_target = target;
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data  = data;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        @(negedge clk);
        cfg.valid = 1'b0;
        if (idx == CFG_IMAGE_STRIDE)
            stride_now = data;
        @(negedge clk);
    endtask

    // loads give no result, so allow the pipeline to empty after the last one
    task automatic drain();
        pix.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial begin : stim
        int          r;
        int          stop_at;
        int unsigned target;
        t_depth_mode mode;
        logic [STRIDE_W-1:0] stride;

        n_items         = 0;
        calm            = 1'b1;
        stride_now      = STRIDE_RESET;
        last_target     = 0;
        pix.valid       = 1'b0;
        pix.operation   = OP_TEST;
        pix.window_base = '0;
        pix.pixel_x     = '0;
        pix.pixel_y     = '0;
        pix.src_depth   = '0;
        pix.is_last     = 1'b0;
        cfg.valid       = 1'b0;
        cfg.index       = CFG_DEPTH_MODE;
        cfg.data        = '0;
        rst_n           = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: less, write on, stride 256
        load_word(16'hFFFF, 32'h8000_0000);
        load_word(16'h0000, 32'h7FFF_FFFF);
        load_word(16'h0100, 32'h0000_0000);
        test_at(16'h0000, 10'd0, 10'd0, 32'h8000_0000, 1'b0);
        test_at(16'hFFFF, 10'd1023, 10'd1023, 32'h7FFF_FFFF, 1'b1);
        // same word back to back, exercises write forwarding
        test_at(16'hFFFF, 10'd1023, 10'd0, 32'h7FFF_FFFE, 1'b0);
        test_at(16'h0100, 10'd0, 10'd1, 32'hFFFF_FFFB, 1'b1);
        drain();

        set_reg(CFG_DEPTH_MODE, {14'h3FFF, MODE_GREATER});
        test_at(16'h0100, 10'd7, 10'd3, 32'hFFFF_FFFA, 1'b0);
        test_at(16'h0100, 10'd7, 10'd3, 32'h0000_0003, 1'b1);
        test_at(16'h0100, 10'd7, 10'd3, 32'h0000_0003, 1'b0);
        drain();

        // always with write disabled must leave the buffer alone
        set_reg(CFG_WRITE_ENABLE, 16'hFFFE);
        set_reg(CFG_DEPTH_MODE, {14'h0, MODE_ALWAYS});
        test_at(16'h0000, 10'd512, 10'd2, 32'd123, 1'b1);
        test_at(16'h0000, 10'd1, 10'd0, 32'd5, 1'b0);
        drain();

        set_reg(CFG_WRITE_ENABLE, 16'h0003);
        set_reg(CFG_DEPTH_MODE, {14'h1555, MODE_LESS});
        test_at(16'h0000, 10'd0, 10'd0, 32'h8000_0000, 1'b1);
        drain();

        // zero stride: every row maps onto the same words
        set_reg(CFG_DEPTH_MODE, {14'h0, MODE_NEVER});
        set_reg(CFG_IMAGE_STRIDE, 16'h0000);
        test_at(16'hFFFF, 10'd0, 10'd1023, 32'h0000_0000, 1'b0);
        test_at(16'h0100, 10'd255, 10'd517, 32'h7FFF_FFFF, 1'b1);
        drain();

        set_reg(CFG_IMAGE_STRIDE, 16'hFFFF);
        set_reg(CFG_DEPTH_MODE, {14'h2AAA, MODE_LESS});
        set_reg(CFG_SPARE, 16'hFFFF);
        test_at(16'h0000, 10'd1023, 10'd1023, 32'h0000_0000, 1'b1);
        load_word(16'h0200, 32'd42);
        test_at(16'h0200, 10'd3, 10'd9, 32'd41, 1'b0);
        load_word(16'h0200, 32'd1);
        test_at(16'h0200, 10'd0, 10'd0, 32'd0, 1'b1);
        drain();

        calm = 1'b0;
        repeat (64) load_word($urandom_range(0, N_WORDS - 1), pick_depth());

        // total transaction count, directed part included
        stop_at = RAND_ITEMS;
        while (n_items < stop_at) begin
            drain();
            calm = ($urandom_range(0, 3) == 0);
            mode = t_depth_mode'($urandom_range(0, 3));
            set_reg(CFG_DEPTH_MODE, {14'($urandom), mode});
            set_reg(CFG_WRITE_ENABLE,
                    {15'($urandom), 1'($urandom_range(0, 99) < 80)});
            r = $urandom_range(0, 99);
            if (r < 10)
                stride = 16'd0;
            else if (r < 20)
                stride = 16'd1;
            else if (r < 30)
                stride = 16'hFFFF;
            else if (r < 45)
                stride = STRIDE_RESET;
            else
                stride = 16'($urandom_range(1, 65535));
            set_reg(CFG_IMAGE_STRIDE, stride);
            if ($urandom_range(0, 6) == 0)
                set_reg(CFG_SPARE, 16'($urandom));

            repeat ($urandom_range(40, 160)) begin
                if (n_items >= stop_at)
                    break;
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    // half the loads hit the word just tested
                    if ($urandom_range(0, 1) == 1)
                        load_word($urandom_range(0, N_WORDS - 1), pick_depth());
                    else
                        load_word(last_target, pick_depth());
                end else if (r < 17) begin
                    drain();
                end else begin
                    if (r < 45)
                        target = last_target;
                    else
                        target = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
                    test_at(target, pick_coord(), pick_coord(), pick_depth(),
                            1'($urandom));
                end
            end
        end

        pix.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (2 * DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
